### sv/sqcorr_pkg.sv
// Shared types, constants and control codes for the squared correlation block.
package sqcorr_pkg;

	// Default values of the top-level parameters.
	localparam int MAX_ROWS_DEF    = 4096;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_COLS_DEF    = 256;

	// Fixed field widths and the fixed-point format of the result.
	localparam int FIELD_W     = 16;
	localparam int Q_W         = 17;
	localparam int FRAC_BITS   = 16;
	localparam int COL_IDX_W   = 8;
	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1 << FRAC_BITS);
	localparam int DIV_STEPS   = Q_W;

	// One input transaction.
	typedef struct packed {
		logic signed [FIELD_W-1:0] truth_sample;
		logic signed [FIELD_W-1:0] estimate_sample;
		logic                      last_in_column;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [Q_W-1:0]       r_squared;
		logic [COL_IDX_W-1:0] column_index;
		logic                 degenerate;
		logic                 too_long;
	} out_item_t;

	// Operand pairs of the shared multiplier, in the order they are issued.
	typedef enum logic [2:0] {
		MS_NXX,
		MS_XX,
		MS_NYY,
		MS_YY,
		MS_NXY,
		MS_XY,
		MS_CC,
		MS_DD
	} mul_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     accum;
		logic     mul_load;
		logic     mul_step;
		logic     store;
		logic     div_step;
		logic     finish;
		mul_sel_t sel;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mul_done;
		logic degen;
	} dp_status_t;

endpackage

### sv/sqcorr_datapath.sv
// Datapath: running sums, shared shift-add multiplier, restoring divider, result register.
module sqcorr_datapath #(
	parameter int MAX_ROWS    = sqcorr_pkg::MAX_ROWS_DEF,
	parameter int SAMPLE_BITS = sqcorr_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_COLS    = sqcorr_pkg::MAX_COLS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sqcorr_pkg::dp_cmd_t    cmd,
	input  sqcorr_pkg::in_item_t   sample,
	output sqcorr_pkg::dp_status_t st,
	output sqcorr_pkg::out_item_t  result
);
	import sqcorr_pkg::*;

	localparam int S       = SAMPLE_BITS;
	localparam int CNT_W   = $clog2(MAX_ROWS + 1);
	localparam int SUM_W   = S + CNT_W;
	localparam int SQ_W    = 2 * S + CNT_W;
	localparam int OW      = 2 * S + 2 * CNT_W + 1;
	localparam int PW      = 2 * OW;
	localparam int RW      = PW + FRAC_BITS;
	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	// Column accumulators.
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [SQ_W-1:0]         sum_xx_q, sum_yy_q;
	logic signed [SQ_W-1:0]  sum_xy_q;
	logic                    ovf_q;
	logic [COL_W-1:0]        col_q;

	// Multiplier, intermediate terms and divider.
	logic [PW-1:0]    mcand_q, prod_q;
	logic [OW-1:0]    mplr_q;
	logic [OW-1:0]    t1_q, dx_q, dy_q, c_q;
	logic [RW-1:0]    rem_q, dsh_q;
	logic [Q_W-1:0]   q_q;
	out_item_t        res_q;

	logic signed [S-1:0]     x, y;
	logic signed [2*S-1:0]   xx, yy, xy;
	logic [SUM_W-1:0]        mag_x, mag_y;
	logic [SQ_W-1:0]         mag_xy;
	logic [OW-1:0]           n_ext, load_a, load_b;
	logic [OW-1:0]           p_low, diff_sat, c_next;
	logic                    neg_a, neg_b;
	logic                    degen;

	// Samples are the low SAMPLE_BITS bits of each field, read as signed.
	assign x  = $signed(S'($unsigned(sample.truth_sample)));
	assign y  = $signed(S'($unsigned(sample.estimate_sample)));
	assign xx = x * x;
	assign yy = y * y;
	assign xy = x * y;

	// Magnitudes of the signed sums; the most negative value maps correctly.
	assign mag_x  = sum_x_q[SUM_W-1] ? $unsigned(-sum_x_q) : $unsigned(sum_x_q);
	assign mag_y  = sum_y_q[SUM_W-1] ? $unsigned(-sum_y_q) : $unsigned(sum_y_q);
	assign mag_xy = sum_xy_q[SQ_W-1] ? $unsigned(-sum_xy_q) : $unsigned(sum_xy_q);
	assign n_ext  = OW'(count_q);

	// Operand selection for the multiplier; the short operand goes in as multiplier.
	always_comb begin
		case (cmd.sel)
			MS_NXX: begin
				load_a = OW'(sum_xx_q);
				load_b = n_ext;
			end
			MS_XX: begin
				load_a = OW'(mag_x);
				load_b = OW'(mag_x);
			end
			MS_NYY: begin
				load_a = OW'(sum_yy_q);
				load_b = n_ext;
			end
			MS_YY: begin
				load_a = OW'(mag_y);
				load_b = OW'(mag_y);
			end
			MS_NXY: begin
				load_a = OW'(mag_xy);
				load_b = n_ext;
			end
			MS_XY: begin
				load_a = OW'(mag_x);
				load_b = OW'(mag_y);
			end
			MS_CC: begin
				load_a = c_q;
				load_b = c_q;
			end
			MS_DD: begin
				load_a = dx_q;
				load_b = dy_q;
			end
			default: begin
				load_a = '0;
				load_b = '0;
			end
		endcase
	end

	// Variance term n*Sqq - Sq^2, held at zero if it would go negative.
	assign p_low    = prod_q[OW-1:0];
	assign diff_sat = (t1_q >= p_low) ? (t1_q - p_low) : '0;

	// Covariance term n*Sxy - Sx*Sy as a magnitude; its sign is lost in the square.
	assign neg_a  = sum_xy_q[SQ_W-1];
	assign neg_b  = sum_x_q[SUM_W-1] ^ sum_y_q[SUM_W-1];
	assign c_next = (neg_a != neg_b) ? (t1_q + p_low) :
			(t1_q >= p_low) ? (t1_q - p_low) : (p_low - t1_q);

	assign degen       = (dx_q == '0) || (dy_q == '0);
	assign st.degen    = degen;
	assign st.mul_done = (mplr_q == '0);
	assign result      = res_q;

	// Column sums, row count, overflow mark and column number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			ovf_q    <= 1'b0;
			col_q    <= '0;
		end else if (cmd.finish) begin
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			ovf_q    <= 1'b0;
			col_q    <= (col_q == COL_W'(MAX_COLS - 1)) ? '0 : col_q + 1'b1;
		end else if (cmd.accum) begin
			if (count_q != CNT_W'(MAX_ROWS)) begin
				count_q  <= count_q + 1'b1;
				sum_x_q  <= sum_x_q + SUM_W'(x);
				sum_y_q  <= sum_y_q + SUM_W'(y);
				sum_xx_q <= sum_xx_q + SQ_W'($unsigned(xx));
				sum_yy_q <= sum_yy_q + SQ_W'($unsigned(yy));
				sum_xy_q <= sum_xy_q + SQ_W'(xy);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Shift-add multiplier: one multiplier bit per cycle, stops when no bits remain.
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			mcand_q <= PW'(load_a);
			mplr_q  <= load_b;
			prod_q  <= '0;
		end else if (cmd.mul_step) begin
			if (mplr_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			mplr_q  <= mplr_q >> 1;
		end
	end

	// Store a finished product into the term it belongs to, and run the divider.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			case (cmd.sel)
				MS_NXX, MS_NYY, MS_NXY: t1_q <= p_low;
				MS_XX: dx_q <= diff_sat;
				MS_YY: dy_q <= diff_sat;
				MS_XY: c_q  <= c_next;
				MS_CC: rem_q <= {prod_q, FRAC_BITS'(0)};
				MS_DD: begin
					dsh_q <= {prod_q, FRAC_BITS'(0)};
					q_q   <= '0;
				end
				default: t1_q <= t1_q;
			endcase
		end else if (cmd.div_step) begin
			if (dsh_q <= rem_q) begin
				rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[Q_W-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[Q_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	// Result register, loaded when the controller hands the column off.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.r_squared    <= degen ? '0 : ((q_q > Q_ONE) ? Q_ONE : q_q);
			res_q.column_index <= COL_IDX_W'(col_q);
			res_q.degenerate   <= degen;
			res_q.too_long     <= ovf_q;
		end
	end

endmodule

### sv/sqcorr_ctrl.sv
// Controller: runs accumulation, up to eight products, any division and the handoff.
module sqcorr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	input  logic                   last_in_column,
	output logic                   sample_ready,
	output logic                   result_valid,
	input  logic                   result_ready,
	input  sqcorr_pkg::dp_status_t st,
	output sqcorr_pkg::dp_cmd_t    cmd
);
	import sqcorr_pkg::*;

	localparam int DCNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		S_ACC,
		S_LOAD,
		S_STEP,
		S_STORE,
		S_DIV,
		S_DONE
	} state_t;

	state_t            state_q;
	mul_sel_t          sel_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              out_valid_q;
	logic              skip;

	// A column whose variance is zero skips the covariance work.
	assign skip         = (sel_q == MS_NXY) && st.degen;
	assign sample_ready = (state_q == S_ACC);
	assign result_valid = out_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd     = '0;
		cmd.sel = sel_q;
		case (state_q)
			S_ACC:   cmd.accum    = sample_valid;
			S_LOAD:  cmd.mul_load = !skip;
			S_STEP:  cmd.mul_step = !st.mul_done;
			S_STORE: cmd.store    = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_DONE:  cmd.finish   = !out_valid_q || result_ready;
			default: cmd          = '0;
		endcase
	end

	// State, operand pair, division count and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			sel_q       <= MS_NXX;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_ACC: begin
					if (sample_valid && last_in_column) begin
						sel_q   <= MS_NXX;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= skip ? S_DONE : S_STEP;
				end
				S_STEP: begin
					if (st.mul_done) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (sel_q == MS_DD) begin
						div_cnt_q <= DCNT_W'(DIV_STEPS - 1);
						state_q   <= S_DIV;
					end else begin
						sel_q   <= mul_sel_t'(sel_q + 1'b1);
						state_q <= S_LOAD;
					end
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				S_DONE: begin
					if (cmd.finish) begin
						state_q <= S_ACC;
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

endmodule

### sv/squared_correlation_r2.sv
// Top level of the squared correlation block: controller plus datapath.
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+-----------------------------------
//  sample   | sample_valid / sample_ready    | truth, estimate, last_in_column
//  result   | result_valid / result_ready    | r_squared, column_index, flags
//
// Rows are accumulated at one transaction per clock cycle while sample_ready is high.
// After a row marked last, sample_ready stays low while one shared shift-add multiplier
// forms up to eight products, one multiplier bit per cycle. Each product has a load step,
// a shift-add step for each significant bit of its multiplier operand (at most
// 2*SAMPLE_BITS + 2*clog2(MAX_ROWS+1) + 1 bits), a step that sees the operand used up
// and a store step. Then come the restoring division, which forms the quotient bit by bit,
// and the handoff. A zero-variance column skips the covariance products and the division.
// The result sits in an output register, so the next column is accumulated while it waits;
// a column end that finds the register still full holds until it is taken.
// Reset clears all sums, counters and control state at once; there is no clearing pass.
module squared_correlation_r2 #(
	parameter int MAX_ROWS    = sqcorr_pkg::MAX_ROWS_DEF,
	parameter int SAMPLE_BITS = sqcorr_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_COLS    = sqcorr_pkg::MAX_COLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sqcorr_pkg::in_item_t  sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output sqcorr_pkg::out_item_t result
);
	import sqcorr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	// Sequencer.
	sqcorr_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.last_in_column (sample.last_in_column),
		.sample_ready   (sample_ready),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.st             (st),
		.cmd            (cmd)
	);

	// Arithmetic.
	sqcorr_datapath #(
		.MAX_ROWS    (MAX_ROWS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_COLS    (MAX_COLS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.st     (st),
		.result (result)
	);

	// A column end stops intake for the end-of-column computation.
	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && sample.last_in_column |=> !sample_ready)
		else $error("sample_ready stayed high after a column end");

	// The squared correlation never exceeds one.
	a_rsq_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.r_squared <= Q_ONE)
		else $error("r_squared above 1.0");

	// A degenerate column reports zero.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |-> result.r_squared == '0)
		else $error("degenerate result with nonzero r_squared");

endmodule
